// ===== src/tsf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsf_pkg: shared types and constants of the turn-signal flasher
// Beat payloads, the configuration set, the flasher state and the codes for
// modes, item kinds and register indexes.
// ----------------------------------------------------------------------------
package tsf_pkg;

   localparam int unsigned CFG_DATA_WIDTH  = 8;
   localparam int unsigned CFG_INDEX_WIDTH = 3;
   localparam int unsigned COUNT_WIDTH     = 8;

   // Register indexes on the configuration port.
   localparam logic [CFG_INDEX_WIDTH-1:0] REG_HAZARD_DEBOUNCE = 3'd0;
   localparam logic [CFG_INDEX_WIDTH-1:0] REG_TURN_PERIOD     = 3'd1;
   localparam logic [CFG_INDEX_WIDTH-1:0] REG_TURN_ON_TICKS   = 3'd2;
   localparam logic [CFG_INDEX_WIDTH-1:0] REG_HAZARD_PERIOD   = 3'd3;
   localparam logic [CFG_INDEX_WIDTH-1:0] REG_HAZARD_ON_TICKS = 3'd4;

   // Register values after reset (20 ms ticks for 760/680 ms periods).
   localparam logic [CFG_DATA_WIDTH-1:0] RST_HAZARD_DEBOUNCE = 8'd20;
   localparam logic [CFG_DATA_WIDTH-1:0] RST_TURN_PERIOD     = 8'd38;
   localparam logic [CFG_DATA_WIDTH-1:0] RST_TURN_ON_TICKS   = 8'd19;
   localparam logic [CFG_DATA_WIDTH-1:0] RST_HAZARD_PERIOD   = 8'd34;
   localparam logic [CFG_DATA_WIDTH-1:0] RST_HAZARD_ON_TICKS = 8'd17;

   // Item kinds.
   localparam logic OP_BUTTON_SAMPLE = 1'b0;
   localparam logic OP_FLASH_TICK    = 1'b1;

   // Indicator modes.
   localparam logic [1:0] MODE_OFF    = 2'd0;
   localparam logic [1:0] MODE_RIGHT  = 2'd1;
   localparam logic [1:0] MODE_LEFT   = 2'd2;
   localparam logic [1:0] MODE_HAZARD = 2'd3;

   // Lamp patterns: bit 0 right, bit 1 left.
   localparam logic [1:0] LAMPS_NONE  = 2'b00;
   localparam logic [1:0] LAMPS_RIGHT = 2'b01;
   localparam logic [1:0] LAMPS_LEFT  = 2'b10;
   localparam logic [1:0] LAMPS_BOTH  = 2'b11;

   typedef struct packed {
      logic opcode;
      logic left_button;
      logic right_button;
   } req_type;

   typedef struct packed {
      logic       right_lamp;
      logic       left_lamp;
      logic [1:0] indicator_mode;
   } rsp_type;

   typedef struct packed {
      logic [CFG_DATA_WIDTH-1:0] hazard_debounce_count;
      logic [CFG_DATA_WIDTH-1:0] turn_period;
      logic [CFG_DATA_WIDTH-1:0] turn_on_ticks;
      logic [CFG_DATA_WIDTH-1:0] hazard_period;
      logic [CFG_DATA_WIDTH-1:0] hazard_on_ticks;
   } cfg_type;

   typedef struct packed {
      logic [1:0]             mode;
      logic [COUNT_WIDTH-1:0] phase_count;
      logic [COUNT_WIDTH-1:0] both_held_count;
      logic                   prev_left;
      logic                   prev_right;
      logic [1:0]             lamp_state;
   } state_type;

endpackage

// ===== src/tsf_step.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsf_step: next-state logic of the turn-signal flasher
// Works out the state after one button sample or flash tick, and the result
// beat that the item produces.
// ----------------------------------------------------------------------------
module tsf_step (
   input  tsf_pkg::req_type   item,
   input  tsf_pkg::cfg_type   cfg,
   input  tsf_pkg::state_type state_cur,
   output tsf_pkg::state_type state_nxt,
   output tsf_pkg::rsp_type   result
);
   import tsf_pkg::*;

   logic [COUNT_WIDTH-1:0] held_inc;
   logic [COUNT_WIDTH-1:0] phase_inc;
   logic [COUNT_WIDTH-1:0] phase_turn;
   logic [COUNT_WIDTH-1:0] phase_haz;
   logic [1:0]             mode_mid;
   logic                   right_edge;
   logic                   left_edge;

   assign held_inc   = state_cur.both_held_count + COUNT_WIDTH'(1);
   assign phase_inc  = state_cur.phase_count + COUNT_WIDTH'(1);
   assign phase_turn = (phase_inc >= cfg.turn_period) ? '0 : phase_inc;
   assign phase_haz  = (phase_turn >= cfg.hazard_period) ? '0 : phase_turn;
   assign right_edge = item.right_button & ~state_cur.prev_right;
   assign left_edge  = item.left_button & ~state_cur.prev_left;

   always_comb begin
      state_nxt = state_cur;
      mode_mid  = state_cur.mode;
      unique case (item.opcode)
         OP_BUTTON_SAMPLE: begin
            state_nxt.prev_left  = item.left_button;
            state_nxt.prev_right = item.right_button;
            if (item.left_button && item.right_button) begin
               if (state_cur.both_held_count < cfg.hazard_debounce_count) begin
                  state_nxt.both_held_count = held_inc;
                  if (held_inc == cfg.hazard_debounce_count) begin
                     state_nxt.mode        = MODE_HAZARD;
                     state_nxt.phase_count = '0;
                  end
               end
            end else begin
               state_nxt.both_held_count = '0;
               // The right edge is resolved first; a left edge in the same
               // sample then sees the mode that the right edge left behind.
               if (right_edge) begin
                  if (state_cur.mode == MODE_RIGHT) begin
                     mode_mid = MODE_OFF;
                  end else begin
                     mode_mid              = MODE_RIGHT;
                     state_nxt.phase_count = '0;
                  end
               end
               state_nxt.mode = mode_mid;
               if (left_edge) begin
                  if (mode_mid == MODE_LEFT) begin
                     state_nxt.mode = MODE_OFF;
                  end else begin
                     state_nxt.mode        = MODE_LEFT;
                     state_nxt.phase_count = '0;
                  end
               end
            end
         end
         OP_FLASH_TICK: begin
            state_nxt.phase_count = phase_turn;
            unique case (state_cur.mode)
               MODE_RIGHT: state_nxt.lamp_state =
                  (phase_turn < cfg.turn_on_ticks) ? LAMPS_RIGHT : LAMPS_NONE;
               MODE_LEFT: state_nxt.lamp_state =
                  (phase_turn < cfg.turn_on_ticks) ? LAMPS_LEFT : LAMPS_NONE;
               MODE_HAZARD: begin
                  state_nxt.phase_count = phase_haz;
                  state_nxt.lamp_state  =
                     (phase_haz < cfg.hazard_on_ticks) ? LAMPS_BOTH : LAMPS_NONE;
               end
               default: state_nxt.lamp_state = LAMPS_NONE;
            endcase
         end
         default: ;
      endcase
   end

   assign result.right_lamp     = state_nxt.lamp_state[0];
   assign result.left_lamp      = state_nxt.lamp_state[1];
   assign result.indicator_mode = state_nxt.mode;

endmodule

// ===== src/turn_signal_flasher.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// turn_signal_flasher: turn-signal controller with hazard mode
// Every request beat (button sample or flash tick) gives exactly one response
// beat with the lamp states and the indicator mode. Each beat is registered
// on entry, handled by one pass of next-state logic and registered again on
// the response side; one request per cycle is sustained while responses are
// taken, and the response register lets a new request enter while the
// previous response still waits.
// ----------------------------------------------------------------------------
//
// A button sample carries the levels of both turn buttons. Holding both for
// hazard_debounce_count samples enters hazard mode; otherwise a rising edge
// on one button switches that side's flashing on or off, and a newly chosen
// mode restarts the phase counter. A flash tick advances the phase counter,
// which wraps at turn_period (and also at hazard_period in hazard mode), and
// lights the lamps of the mode while the phase is below the on-tick count.
// Registers are written through the csr_ port, which is always ready; write
// them only while no request is in flight. Indexes beyond the register list
// are ignored.
module turn_signal_flasher (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  tsf_pkg::req_type                      req_data,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output tsf_pkg::rsp_type                      rsp_data,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [tsf_pkg::CFG_INDEX_WIDTH-1:0]   csr_index,
   input  logic [tsf_pkg::CFG_DATA_WIDTH-1:0]    csr_data
);
   import tsf_pkg::*;

   cfg_type   cfg_ff;
   cfg_type   cfg_in;
   state_type state_ff;
   state_type state_in;
   req_type   item_ff;
   logic      item_valid_ff;
   logic      rsp_valid_ff;
   rsp_type   rsp_data_ff;
   rsp_type   result;
   logic      advance;

   // The held request moves on whenever the response register is free or
   // its beat is being taken in this cycle.
   assign advance   = item_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !item_valid_ff || advance;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   tsf_step u_step (
      .item      (item_ff),
      .cfg       (cfg_ff),
      .state_cur (state_ff),
      .state_nxt (state_in),
      .result    (result)
   );

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            REG_HAZARD_DEBOUNCE: cfg_in.hazard_debounce_count = csr_data;
            REG_TURN_PERIOD:     cfg_in.turn_period           = csr_data;
            REG_TURN_ON_TICKS:   cfg_in.turn_on_ticks         = csr_data;
            REG_HAZARD_PERIOD:   cfg_in.hazard_period         = csr_data;
            REG_HAZARD_ON_TICKS: cfg_in.hazard_on_ticks       = csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.hazard_debounce_count <= RST_HAZARD_DEBOUNCE;
         cfg_ff.turn_period           <= RST_TURN_PERIOD;
         cfg_ff.turn_on_ticks         <= RST_TURN_ON_TICKS;
         cfg_ff.hazard_period         <= RST_HAZARD_PERIOD;
         cfg_ff.hazard_on_ticks       <= RST_HAZARD_ON_TICKS;
         state_ff                     <= '0;
         item_valid_ff                <= 1'b0;
         rsp_valid_ff                 <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
         if (advance) begin
            state_ff <= state_in;
         end
         if (req_ready) begin
            item_valid_ff <= req_valid;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers carry no reset.
   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         item_ff <= req_data;
      end
      if (advance) begin
         rsp_data_ff <= result;
      end
   end

   // A button sample never changes the stored lamp pattern.
   assert property (@(posedge clock) disable iff (reset)
      advance && item_ff.opcode == OP_BUTTON_SAMPLE
      |=> state_ff.lamp_state == $past(state_ff.lamp_state))
      else $error("lamp state changed on a button sample");

   // After a flash tick the phase is zero or below the turn period.
   assert property (@(posedge clock) disable iff (reset)
      advance && item_ff.opcode == OP_FLASH_TICK
      |=> state_ff.phase_count == '0 || state_ff.phase_count < cfg_ff.turn_period)
      else $error("phase counter beyond turn period after a tick");

   // A held request that cannot move on is kept, not dropped.
   assert property (@(posedge clock) disable iff (reset)
      item_valid_ff && !advance |=> item_valid_ff && $stable(item_ff))
      else $error("stalled request lost");

   // The response register only fills from a request that moved on.
   assert property (@(posedge clock) disable iff (reset)
      !rsp_valid_ff ##1 rsp_valid_ff |-> $past(advance))
      else $error("response beat without a request");

endmodule
